[design/sdrx_pkg.sv]
// ----------------------------------------------------------------------------
// sdrx_pkg
// Types, constants and the byte-wide CRC16 for the SD SPI data block receiver.
// ----------------------------------------------------------------------------
package sdrx_pkg;

  localparam int MAX_BLOCK_BYTES = 512;

  localparam int WAIT_W   = 16;
  localparam int BLEN_W   = 10;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [WAIT_W-1:0] WAIT_LIMIT_RST   = 16'd255;
  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST = 10'd512;

  localparam logic REG_WAIT_LIMIT   = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  localparam logic [7:0]  START_TOKEN = 8'hFE;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_BAD_CRC  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_ECC      = 3'd4;
  localparam logic [2:0] ST_CTRL     = 3'd5;
  localparam logic [2:0] ST_DATA_ERR = 3'd6;
  localparam logic [2:0] ST_GENERAL  = 3'd7;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] status_code;
    logic       last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] err_code(input logic [7:0] b);
    logic [2:0] code;
    if (b[3]) begin
      code = ST_RANGE;
    end else if (b[2]) begin
      code = ST_ECC;
    end else if (b[1]) begin
      code = ST_CTRL;
    end else if (b[0]) begin
      code = ST_DATA_ERR;
    end else begin
      code = ST_GENERAL;
    end
    return code;
  endfunction

endpackage

[design/sdrx_ifs.sv]
// ----------------------------------------------------------------------------
// sdrx interfaces
// Valid/ready channels for received bytes and for block results.
// ----------------------------------------------------------------------------
interface sdrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdrx_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] status_code;
  logic       last;

  modport source (output valid, output result_kind, output data_byte,
                  output status_code, output last, input ready);
  modport sink (input valid, input result_kind, input data_byte,
                input status_code, input last, output ready);
endinterface

[design/sdrx_regs.sv]
// ----------------------------------------------------------------------------
// sdrx_regs
// APB register file: wait limit and block length.
// ----------------------------------------------------------------------------
module sdrx_regs
  import sdrx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [WAIT_W-1:0] wait_limit,
  output logic [BLEN_W-1:0] block_length
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit   <= WAIT_LIMIT_RST;
      block_length <= BLOCK_LENGTH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WAIT_LIMIT:   wait_limit   <= pwdata[WAIT_W-1:0];
        REG_BLOCK_LENGTH: block_length <= pwdata[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WAIT_LIMIT:   prdata = APB_DW'(wait_limit);
      REG_BLOCK_LENGTH: prdata = APB_DW'(block_length);
      default:          prdata = '0;
    endcase
  end

endmodule

[design/sdrx_core.sv]
// ----------------------------------------------------------------------------
// sdrx_core
// Token wait, data pass-through with CRC16, CRC check and status decode.
// ----------------------------------------------------------------------------
module sdrx_core
  import sdrx_pkg::*;
#(
  parameter int MaxBlockBytes = MAX_BLOCK_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic [WAIT_W-1:0] wait_limit,
  input  logic [BLEN_W-1:0] block_length,
  output logic              emit,
  output result_t           res
);

  localparam int CntW = $clog2(MaxBlockBytes + 1);
  localparam int LenW = (CntW > BLEN_W) ? CntW : BLEN_W;

  phase_t            phase, phase_next;
  logic [WAIT_W-1:0] idle_count, idle_count_next;
  logic [CntW-1:0]   byte_count, byte_count_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [7:0]        crc_high_byte, crc_high_byte_next;

  logic [WAIT_W-1:0] limit;
  logic [WAIT_W-1:0] idle_inc;
  logic [LenW-1:0]   blen_ext;
  logic [LenW-1:0]   len_eff;
  logic [CntW:0]     cnt_inc;
  logic [15:0]       crc_upd;

  assign limit    = (wait_limit == '0) ? WAIT_W'(1) : wait_limit;
  assign idle_inc = idle_count + WAIT_W'(1);
  assign blen_ext = LenW'(block_length);
  assign len_eff  = (blen_ext == '0) ? LenW'(1) :
                    (blen_ext > LenW'(MaxBlockBytes)) ? LenW'(MaxBlockBytes) : blen_ext;
  assign cnt_inc  = {1'b0, byte_count} + (CntW + 1)'(1);
  assign crc_upd  = crc_byte(running_crc, rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      idle_count    <= '0;
      byte_count    <= '0;
      running_crc   <= '0;
      crc_high_byte <= '0;
    end else begin
      phase         <= phase_next;
      idle_count    <= idle_count_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  always_comb begin
    logic       status;
    logic [2:0] code;
    phase_next         = phase;
    idle_count_next    = idle_count;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    status             = 1'b0;
    code               = ST_OK;
    emit               = 1'b0;
    res                = '0;

    if (accept) begin
      unique case (phase)
        PH_WAIT: begin
          if (rx_byte == START_TOKEN) begin
            phase_next       = PH_DATA;
            idle_count_next  = '0;
            byte_count_next  = '0;
            running_crc_next = '0;
          end else if (rx_byte == IDLE_BYTE) begin
            if (idle_inc >= limit) begin
              status = 1'b1;
              code   = ST_TIMEOUT;
            end else begin
              idle_count_next = idle_inc;
            end
          end else begin
            status = 1'b1;
            code   = err_code(rx_byte);
          end
        end
        PH_DATA: begin
          running_crc_next = crc_upd;
          byte_count_next  = CntW'(cnt_inc);
          if ((LenW + 1)'(cnt_inc) >= (LenW + 1)'(len_eff)) begin
            phase_next = PH_CRC_HI;
          end
          emit            = 1'b1;
          res.result_kind = KIND_DATA;
          res.data_byte   = rx_byte;
        end
        PH_CRC_HI: begin
          crc_high_byte_next = rx_byte;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          status = 1'b1;
          code   = ({crc_high_byte, rx_byte} == running_crc) ? ST_OK : ST_BAD_CRC;
        end
        default: ;
      endcase

      if (status) begin
        phase_next         = PH_WAIT;
        idle_count_next    = '0;
        byte_count_next    = '0;
        running_crc_next   = '0;
        crc_high_byte_next = '0;
        emit               = 1'b1;
        res.result_kind    = KIND_STATUS;
        res.status_code    = code;
        res.last           = 1'b1;
      end
    end
  end

endmodule

[design/sd_spi_data_block_receiver.sv]
// Latency: a result beat is valid the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while results are taken; the output register frees in
// the cycle it is taken. Reset (rst, synchronous): rearms to wait for the start token,
// empties the output register, and sets wait_limit to 255 and block_length to 512.
// ----------------------------------------------------------------------------
// sd_spi_data_block_receiver
// SD SPI-mode read data block receiver with CRC16 check and error token decode.
// ----------------------------------------------------------------------------
module sd_spi_data_block_receiver
  import sdrx_pkg::*;
#(
  parameter int MaxBlockBytes = MAX_BLOCK_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  sdrx_byte_if.sink         rx,
  sdrx_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [WAIT_W-1:0] wait_limit;
  logic [BLEN_W-1:0] block_length;
  logic              rx_accept;
  logic              emit;
  result_t           res;
  logic              res_valid;
  result_t           res_q;

  sdrx_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .wait_limit   (wait_limit),
    .block_length (block_length)
  );

  sdrx_core #(
    .MaxBlockBytes (MaxBlockBytes)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (rx_accept),
    .rx_byte      (rx.rx_byte),
    .wait_limit   (wait_limit),
    .block_length (block_length),
    .emit         (emit),
    .res          (res)
  );

  assign rx.ready  = !res_valid || result.ready;
  assign rx_accept = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_accept) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && emit) begin
      res_q <= res;
    end
  end

  assign result.valid       = res_valid;
  assign result.result_kind = res_q.result_kind;
  assign result.data_byte   = res_q.data_byte;
  assign result.status_code = res_q.status_code;
  assign result.last        = res_q.last;

endmodule
